/* src/dqp_pkg.sv */
// Shared types and constants for the dual queue duplicate purge block.
// Holds queue sizing, command and status codes, and the control/status
// structs that join the controller to the datapath. No dependencies.
package dqp_pkg;

	// Queue sizing
	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int IDX_IN_W    = 4;
	localparam int CMP_W       = (CNT_W > IDX_IN_W) ? CNT_W : IDX_IN_W;
	localparam int DATA_W      = 32;

	// Command codes
	typedef enum logic [1:0] {
		CMD_ENQ    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_PURGE  = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	// Result status codes
	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_FULL      = 2'd1,
		STS_NOT_FOUND = 2'd2,
		STS_BAD_INDEX = 2'd3
	} status_t;

	// Step commands from controller to datapath
	typedef struct packed {
		logic load;
		logic enq;
		logic read_issue;
		logic read_take;
		logic scan_issue;
		logic scan_check;
		logic scan_commit;
		logic pg_issue_b;
		logic pg_load_b;
		logic pg_issue_a;
		logic pg_cmp_a;
		logic pg_write;
		logic pg_commit;
		logic publish;
	} ctl_t;

	// Status from datapath to controller
	typedef struct packed {
		cmd_t cmd;
		logic scan_done;
		logic pg_done;
		logic inner_done;
	} sts_t;

endpackage

/* src/dqp_ctrl.sv */
// Controller state machine for the dual queue duplicate purge block.
// Sequences enqueue, remove, purge and read steps and owns the result
// valid flag. Depends on dqp_pkg.
module dqp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  dqp_pkg::sts_t sts,
	output dqp_pkg::ctl_t ctl
);
	import dqp_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE      = 10'b0000000001,
		ST_DISPATCH  = 10'b0000000010,
		ST_READ_WAIT = 10'b0000000100,
		ST_SCAN_RD   = 10'b0000001000,
		ST_SCAN_CHK  = 10'b0000010000,
		ST_PG_RD_B   = 10'b0000100000,
		ST_PG_LD_B   = 10'b0001000000,
		ST_PG_RD_A   = 10'b0010000000,
		ST_PG_CMP_A  = 10'b0100000000,
		ST_DONE      = 10'b1000000000
	} fsm_state_t;

	fsm_state_t state_q;
	fsm_state_t state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	// Decode next state and step commands
	always_comb begin
		ctl     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d  = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (sts.cmd)
					CMD_ENQ: begin
						ctl.enq = 1'b1;
						state_d = ST_DONE;
					end
					CMD_REMOVE: state_d = ST_SCAN_RD;
					CMD_PURGE:  state_d = ST_PG_RD_B;
					CMD_READ: begin
						ctl.read_issue = 1'b1;
						state_d        = ST_READ_WAIT;
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_READ_WAIT: begin
				ctl.read_take = 1'b1;
				state_d       = ST_DONE;
			end
			ST_SCAN_RD: begin
				if (sts.scan_done) begin
					ctl.scan_commit = 1'b1;
					state_d         = ST_DONE;
				end else begin
					ctl.scan_issue = 1'b1;
					state_d        = ST_SCAN_CHK;
				end
			end
			ST_SCAN_CHK: begin
				ctl.scan_check = 1'b1;
				state_d        = ST_SCAN_RD;
			end
			ST_PG_RD_B: begin
				if (sts.pg_done) begin
					ctl.pg_commit = 1'b1;
					state_d       = ST_DONE;
				end else begin
					ctl.pg_issue_b = 1'b1;
					state_d        = ST_PG_LD_B;
				end
			end
			ST_PG_LD_B: begin
				ctl.pg_load_b = 1'b1;
				state_d       = ST_PG_RD_A;
			end
			ST_PG_RD_A: begin
				if (sts.inner_done) begin
					ctl.pg_write = 1'b1;
					state_d      = ST_PG_RD_B;
				end else begin
					ctl.pg_issue_a = 1'b1;
					state_d        = ST_PG_CMP_A;
				end
			end
			ST_PG_CMP_A: begin
				ctl.pg_cmp_a = 1'b1;
				state_d      = ST_PG_RD_A;
			end
			ST_DONE: begin
				if (out_free) begin
					ctl.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Advance state and hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.publish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_ctl_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(ctl))
		else $error("more than one step command at once");
	a_publish_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.publish |-> (!out_valid_q || !out_stall))
		else $error("result overwritten while stalled");
	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_DISPATCH && out_valid_q == $past(out_valid_q
		&& out_stall) || state_q == ST_DISPATCH))
		else $error("accepted beat not dispatched");
`endif

endmodule

/* src/dqp_datapath.sv */
// Datapath for the dual queue duplicate purge block: two queue memories,
// occupancies, scan pointers, working result and output registers.
// Driven by dqp_ctrl step commands. Depends on dqp_pkg.
module dqp_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [1:0]                  command,
	input  logic                        queue_select,
	input  logic signed [31:0]          value,
	input  logic [3:0]                  index,
	input  dqp_pkg::ctl_t               ctl,
	output dqp_pkg::sts_t               sts,
	output logic [1:0]                  status,
	output logic [4:0]                  removed_count,
	output logic signed [31:0]          read_value,
	output logic [4:0]                  count_a,
	output logic [4:0]                  count_b
);
	import dqp_pkg::*;

	// Queue storage
	logic [DATA_W-1:0] mem_a_q [QUEUE_DEPTH];
	logic [DATA_W-1:0] mem_b_q [QUEUE_DEPTH];
	logic [DATA_W-1:0] a_rdata_q;
	logic [DATA_W-1:0] b_rdata_q;

	// Control state
	logic [CNT_W-1:0]  occ_a_q;
	logic [CNT_W-1:0]  occ_b_q;

	// Working registers
	cmd_t              cmd_q;
	logic              sel_q;
	logic [DATA_W-1:0] val_q;
	logic [IDX_IN_W-1:0] idx_q;
	logic [CNT_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  wr_ptr_q;
	logic [CNT_W-1:0]  j_ptr_q;
	logic              found_q;
	logic              hit_q;
	logic [DATA_W-1:0] cur_q;
	status_t           st_q;
	logic [CNT_W-1:0]  rem_q;
	logic [DATA_W-1:0] rv_q;

	// Result registers
	logic [1:0]        status_q;
	logic [4:0]        removed_q;
	logic [DATA_W-1:0] read_value_q;
	logic [4:0]        count_a_q;
	logic [4:0]        count_b_q;

	// Memory ports
	logic              a_we, a_re, b_we, b_re;
	logic [IDX_W-1:0]  a_waddr, a_raddr, b_waddr, b_raddr;
	logic [DATA_W-1:0] a_wdata, b_wdata;

	logic [CNT_W-1:0]  occ_sel;
	logic              full_sel;
	logic              idx_ok;
	logic [DATA_W-1:0] scan_data;
	logic              keep_scan;

	assign occ_sel   = sel_q ? occ_b_q : occ_a_q;
	assign full_sel  = (occ_sel >= CNT_W'(QUEUE_DEPTH));
	assign idx_ok    = (CMP_W'(idx_q) < CMP_W'(occ_sel));
	assign scan_data = sel_q ? b_rdata_q : a_rdata_q;
	assign keep_scan = found_q || (scan_data != val_q);

	assign sts.cmd        = cmd_q;
	assign sts.scan_done  = (rd_ptr_q >= occ_sel);
	assign sts.pg_done    = (rd_ptr_q >= occ_b_q);
	assign sts.inner_done = hit_q || (j_ptr_q >= occ_a_q);

	assign status        = status_q;
	assign removed_count = removed_q;
	assign read_value    = read_value_q;
	assign count_a       = count_a_q;
	assign count_b       = count_b_q;

	// Steer memory reads and writes for the current step
	always_comb begin
		a_we    = 1'b0;
		a_re    = 1'b0;
		b_we    = 1'b0;
		b_re    = 1'b0;
		a_waddr = '0;
		a_raddr = '0;
		b_waddr = '0;
		b_raddr = '0;
		a_wdata = val_q;
		b_wdata = val_q;
		if (ctl.enq && !full_sel) begin
			if (sel_q) begin
				b_we    = 1'b1;
				b_waddr = occ_b_q[IDX_W-1:0];
			end else begin
				a_we    = 1'b1;
				a_waddr = occ_a_q[IDX_W-1:0];
			end
		end
		if (ctl.read_issue) begin
			a_re    = !sel_q;
			b_re    = sel_q;
			a_raddr = IDX_W'(idx_q);
			b_raddr = IDX_W'(idx_q);
		end
		if (ctl.scan_issue) begin
			a_re    = !sel_q;
			b_re    = sel_q;
			a_raddr = rd_ptr_q[IDX_W-1:0];
			b_raddr = rd_ptr_q[IDX_W-1:0];
		end
		if (ctl.scan_check && keep_scan) begin
			a_we    = !sel_q;
			b_we    = sel_q;
			a_waddr = wr_ptr_q[IDX_W-1:0];
			b_waddr = wr_ptr_q[IDX_W-1:0];
			a_wdata = scan_data;
			b_wdata = scan_data;
		end
		if (ctl.pg_issue_b) begin
			b_re    = 1'b1;
			b_raddr = rd_ptr_q[IDX_W-1:0];
		end
		if (ctl.pg_issue_a) begin
			a_re    = 1'b1;
			a_raddr = j_ptr_q[IDX_W-1:0];
		end
		if (ctl.pg_write && !hit_q) begin
			b_we    = 1'b1;
			b_waddr = wr_ptr_q[IDX_W-1:0];
			b_wdata = cur_q;
		end
	end

	// Queue memories with registered read data
	always_ff @(posedge clk) begin
		if (a_we) begin
			mem_a_q[a_waddr] <= a_wdata;
		end
		if (a_re) begin
			a_rdata_q <= mem_a_q[a_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (b_we) begin
			mem_b_q[b_waddr] <= b_wdata;
		end
		if (b_re) begin
			b_rdata_q <= mem_b_q[b_raddr];
		end
	end

	// Update occupancies
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_a_q <= '0;
			occ_b_q <= '0;
		end else begin
			if (ctl.enq && !full_sel) begin
				if (sel_q) begin
					occ_b_q <= occ_b_q + 1'b1;
				end else begin
					occ_a_q <= occ_a_q + 1'b1;
				end
			end
			if (ctl.scan_commit && found_q) begin
				if (sel_q) begin
					occ_b_q <= occ_b_q - 1'b1;
				end else begin
					occ_a_q <= occ_a_q - 1'b1;
				end
			end
			if (ctl.pg_commit) begin
				occ_b_q <= wr_ptr_q;
			end
		end
	end

	// Capture the command, walk the pointers and build the result
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q    <= cmd_t'(command);
			sel_q    <= queue_select;
			val_q    <= value;
			idx_q    <= index;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			j_ptr_q  <= '0;
			found_q  <= 1'b0;
			hit_q    <= 1'b0;
			st_q     <= STS_OK;
			rem_q    <= '0;
			rv_q     <= '0;
		end
		if (ctl.enq && full_sel) begin
			st_q <= STS_FULL;
		end
		if (ctl.read_issue && !idx_ok) begin
			st_q <= STS_BAD_INDEX;
		end
		if (ctl.read_take && idx_ok) begin
			rv_q <= scan_data;
		end
		if (ctl.scan_check) begin
			if (!keep_scan) begin
				found_q <= 1'b1;
			end else begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			rd_ptr_q <= rd_ptr_q + 1'b1;
		end
		if (ctl.scan_commit) begin
			if (found_q) begin
				rem_q <= CNT_W'(1);
			end else begin
				st_q <= STS_NOT_FOUND;
			end
		end
		if (ctl.pg_load_b) begin
			cur_q   <= b_rdata_q;
			j_ptr_q <= '0;
			hit_q   <= 1'b0;
		end
		if (ctl.pg_cmp_a) begin
			if (a_rdata_q == cur_q) begin
				hit_q <= 1'b1;
			end
			j_ptr_q <= j_ptr_q + 1'b1;
		end
		if (ctl.pg_write) begin
			if (!hit_q) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			rd_ptr_q <= rd_ptr_q + 1'b1;
		end
		if (ctl.pg_commit) begin
			rem_q <= rd_ptr_q - wr_ptr_q;
		end
		if (ctl.publish) begin
			status_q     <= st_q;
			removed_q    <= 5'(rem_q);
			read_value_q <= rv_q;
			count_a_q    <= 5'(occ_a_q);
			count_b_q    <= 5'(occ_b_q);
		end
	end

`ifndef ASSERT_OFF
	a_occ_a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_a_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue A occupancy above depth");
	a_occ_b_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_b_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue B occupancy above depth");
	a_wr_behind_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.scan_check || ctl.pg_write) |-> (wr_ptr_q <= rd_ptr_q))
		else $error("compaction write pointer passed read pointer");
`endif

endmodule

/* src/dual_queue_duplicate_purge.sv */
// Dual bounded queue block with first-match remove and duplicate purge.
// Channels: an input beat (command, queue_select, value, index) and a result
// beat (status, removed_count, read_value, count_a, count_b), each with
// valid/stall; a beat moves on a clock edge with valid high and stall low.
// One command is worked at a time. in_stall is high from the accepted beat
// until its result is loaded into the output register; a new beat is taken
// while an earlier result still waits there.
// From accept to result the command passes dispatch, its own steps and a
// done step that loads the result register. Enqueue writes in dispatch;
// read issues in dispatch and takes the data in the next step. Memory read
// data is registered, so each compared entry costs an issue step and a
// check step; remove walks the target queue, and the purge walks A for
// each entry of B until the first match.
// The next beat can be taken in the cycle after the result is loaded.
// A stalled receiver holds the result register; a finished command waits
// in its last step until the register frees up, so no result is dropped.
// Reset empties both queues and clears the result valid flag; queue storage
// itself is not cleared.
// Depends on dqp_pkg, dqp_ctrl and dqp_datapath.
module dual_queue_duplicate_purge (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         command,
	input  logic               queue_select,
	input  logic signed [31:0] value,
	input  logic [3:0]         index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [4:0]         removed_count,
	output logic signed [31:0] read_value,
	output logic [4:0]         count_a,
	output logic [4:0]         count_b
);
	import dqp_pkg::*;

	ctl_t ctl;
	sts_t sts;

	// Sequence the steps
	dqp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	// Hold the queues and build the result
	dqp_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.command       (command),
		.queue_select  (queue_select),
		.value         (value),
		.index         (index),
		.ctl           (ctl),
		.sts           (sts),
		.status        (status),
		.removed_count (removed_count),
		.read_value    (read_value),
		.count_a       (count_a),
		.count_b       (count_b)
	);

endmodule
